// ===== hdl/ipv4_l4_header_extractor_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef IPV4_L4_HEADER_EXTRACTOR_TOP_MACROS_SVH
`define IPV4_L4_HEADER_EXTRACTOR_TOP_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define L4HX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("l4hx assertion failed");

// Clocked assertion that also holds while reset is asserted.
`define L4HX_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("l4hx assertion failed");

`endif

// ===== hdl/l4hx_pkg.sv =====
// Package: frame offsets, protocol codes and the summary record layout.
`timescale 1ns / 1ps
`default_nettype none

package l4hx_pkg;

  localparam int unsigned CNT_W     = 7;
  localparam int unsigned LEN_W     = CNT_W + 1;
  localparam int unsigned IN_DATA_W = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  // fixed byte offsets in the frame
  localparam logic [CNT_W-1:0] POS_ETYPE_HI = 7'd12;
  localparam logic [CNT_W-1:0] POS_ETYPE_LO = 7'd13;
  localparam logic [CNT_W-1:0] POS_IHL      = 7'd14;
  localparam logic [CNT_W-1:0] POS_PROTO    = 7'd23;
  localparam logic [CNT_W-1:0] POS_SRC_LO   = 7'd26;
  localparam logic [CNT_W-1:0] POS_SRC_HI   = 7'd29;
  localparam logic [CNT_W-1:0] POS_DST_LO   = 7'd30;
  localparam logic [CNT_W-1:0] POS_DST_HI   = 7'd33;
  localparam logic [CNT_W-1:0] POS_IP_END   = 7'd34;

  localparam logic [LEN_W-1:0] ETH_HDR_LEN = 8'd14;
  localparam logic [LEN_W-1:0] MIN_IP_END  = 8'd34;
  localparam logic [LEN_W-1:0] TCP_HDR_LEN = 8'd20;
  localparam logic [LEN_W-1:0] UDP_HDR_LEN = 8'd8;
  localparam logic [LEN_W-1:0] TCP_FLAGS_OFS = 8'd13;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [3:0]  IHL_MIN   = 4'd5;

  // TCP flags byte bits
  localparam int unsigned TCP_FIN_BIT = 0;
  localparam int unsigned TCP_SYN_BIT = 1;
  localparam int unsigned TCP_ACK_BIT = 4;

  // summary record, last field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic        fin_flag;
    logic        ack_flag;
    logic        syn_flag;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [7:0]  proto_num;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } rec_t;

  localparam int unsigned OUT_DATA_W = $bits(rec_t);

endpackage

`default_nettype wire

// ===== hdl/ipv4_l4_header_extractor_top.sv =====
// Top level: Ethernet/IPv4 TCP/UDP header field extractor.
//
// Takes one frame byte per word on the slave stream (tlast on the final byte)
// and, for each frame, sends one summary word on the master stream: IPv4
// addresses, protocol, transport ports and TCP SYN/ACK/FIN, with tuser set
// when the frame is IPv4 TCP or UDP and long enough to hold the whole
// transport header. Fields not reached are zero. A byte is accepted every
// cycle unless the skid register holds a summary; the byte counter and
// capture registers update in the accept cycle, and the summary is formed
// from them plus the final byte and registered. The two-entry output buffer
// (output register plus skid register) keeps tready registered and lets
// input continue while a summary waits; tready drops only when both hold a
// summary. The byte count saturates at 127, beyond every capture offset.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_l4_header_extractor_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // [7:0] data_byte
  input  wire logic [l4hx_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [31:0] src_addr, [63:32] dst_addr, [71:64] proto_num, [87:72] src_port,
  // [103:88] dst_port, [104] syn_flag, [105] ack_flag, [106] fin_flag, rest 0
  output      logic [l4hx_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [0] valid_res
  output      logic                              m_axis_tuser_o
);

  localparam int unsigned CW = l4hx_pkg::CNT_W;
  localparam int unsigned LW = l4hx_pkg::LEN_W;

  // capture state
  logic [CW-1:0] byte_count_q, byte_count_d;
  logic [15:0]   ether_kind_q, ether_kind_d;
  logic [3:0]    header_words_q, header_words_d;
  logic [7:0]    proto_q, proto_d;
  logic [31:0]   src_addr_q, src_addr_d;
  logic [31:0]   dst_addr_q, dst_addr_d;
  logic [15:0]   src_port_q, src_port_d;
  logic [15:0]   dst_port_q, dst_port_d;
  logic [2:0]    flag_bits_q, flag_bits_d;   // bit0 FIN, bit1 SYN, bit2 ACK

  // output buffer
  logic            out_valid_q, out_valid_d;
  l4hx_pkg::rec_t  out_rec_q, out_rec_d;
  logic            out_user_q, out_user_d;
  logic            skid_valid_q, skid_valid_d;
  l4hx_pkg::rec_t  skid_rec_q, skid_rec_d;
  logic            skid_user_q, skid_user_d;

  logic            s_fire, push, pop;
  logic [CW-1:0]   pos;
  logic [7:0]      b;
  logic [LW-1:0]   pos_w, off_cur, off_new, len;
  l4hx_pkg::rec_t  rec;
  logic            rec_user;

  assign s_axis_tready_o = !skid_valid_q;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = s_fire && s_axis_tlast_i;
  assign pop             = out_valid_q && m_axis_tready_i;

  assign pos   = byte_count_q;
  assign b     = s_axis_tdata_i;
  assign pos_w = {1'b0, pos};
  // transport offset from the IHL held before this byte
  assign off_cur = l4hx_pkg::ETH_HDR_LEN + {2'b00, header_words_q, 2'b00};

  // field capture for the current byte
  always_comb begin
    ether_kind_d   = ether_kind_q;
    header_words_d = header_words_q;
    proto_d        = proto_q;
    src_addr_d     = src_addr_q;
    dst_addr_d     = dst_addr_q;
    src_port_d     = src_port_q;
    dst_port_d     = dst_port_q;
    flag_bits_d    = flag_bits_q;

    if (pos == l4hx_pkg::POS_ETYPE_HI) begin
      ether_kind_d = {b, 8'h00};
    end else if (pos == l4hx_pkg::POS_ETYPE_LO) begin
      ether_kind_d = {ether_kind_q[15:8], b};
    end else if (pos == l4hx_pkg::POS_IHL) begin
      header_words_d = b[3:0];
    end else if (pos == l4hx_pkg::POS_PROTO) begin
      proto_d = b;
    end else if (pos >= l4hx_pkg::POS_SRC_LO && pos <= l4hx_pkg::POS_SRC_HI) begin
      src_addr_d = {src_addr_q[23:0], b};
    end else if (pos >= l4hx_pkg::POS_DST_LO && pos <= l4hx_pkg::POS_DST_HI) begin
      dst_addr_d = {dst_addr_q[23:0], b};
    end

    if (pos >= l4hx_pkg::POS_IP_END && header_words_q >= l4hx_pkg::IHL_MIN) begin
      if (pos_w == off_cur) begin
        src_port_d = {b, 8'h00};
      end else if (pos_w == off_cur + 8'd1) begin
        src_port_d = {src_port_q[15:8], b};
      end else if (pos_w == off_cur + 8'd2) begin
        dst_port_d = {b, 8'h00};
      end else if (pos_w == off_cur + 8'd3) begin
        dst_port_d = {dst_port_q[15:8], b};
      end else if (pos_w == off_cur + l4hx_pkg::TCP_FLAGS_OFS) begin
        flag_bits_d = {b[l4hx_pkg::TCP_ACK_BIT], b[l4hx_pkg::TCP_SYN_BIT],
                       b[l4hx_pkg::TCP_FIN_BIT]};
      end
    end

    byte_count_d = (byte_count_q < l4hx_pkg::COUNT_MAX) ? byte_count_q + 7'd1
                                                         : byte_count_q;
  end

  // summary record from the state including the final byte
  assign len     = pos_w + 8'd1;
  assign off_new = l4hx_pkg::ETH_HDR_LEN + {2'b00, header_words_d, 2'b00};

  always_comb begin
    rec      = '0;
    rec_user = 1'b0;
    if (ether_kind_d == l4hx_pkg::ETH_IPV4 && len >= l4hx_pkg::MIN_IP_END) begin
      rec.src_addr  = src_addr_d;
      rec.dst_addr  = dst_addr_d;
      rec.proto_num = proto_d;
      if (header_words_d >= l4hx_pkg::IHL_MIN) begin
        if (proto_d == l4hx_pkg::PROTO_TCP && len >= off_new + l4hx_pkg::TCP_HDR_LEN) begin
          rec_user     = 1'b1;
          rec.src_port = src_port_d;
          rec.dst_port = dst_port_d;
          rec.syn_flag = flag_bits_d[1];
          rec.ack_flag = flag_bits_d[2];
          rec.fin_flag = flag_bits_d[0];
        end else if (proto_d == l4hx_pkg::PROTO_UDP &&
                     len >= off_new + l4hx_pkg::UDP_HDR_LEN) begin
          rec_user     = 1'b1;
          rec.src_port = src_port_d;
          rec.dst_port = dst_port_d;
        end
      end
    end
  end

  // output register plus skid register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_rec_d    = out_rec_q;
    out_user_d   = out_user_q;
    skid_valid_d = skid_valid_q;
    skid_rec_d   = skid_rec_q;
    skid_user_d  = skid_user_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_rec_d    = skid_rec_q;
        out_user_d   = skid_user_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_rec_d   = rec;
        out_user_d  = rec_user;
      end else begin
        skid_valid_d = 1'b1;
        skid_rec_d   = rec;
        skid_user_d  = rec_user;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      ether_kind_q   <= '0;
      header_words_q <= '0;
      proto_q        <= '0;
      src_addr_q     <= '0;
      dst_addr_q     <= '0;
      src_port_q     <= '0;
      dst_port_q     <= '0;
      flag_bits_q    <= '0;
    end else if (s_fire) begin
      if (s_axis_tlast_i) begin
        // frame done: start the next one clean
        byte_count_q   <= '0;
        ether_kind_q   <= '0;
        header_words_q <= '0;
        proto_q        <= '0;
        src_addr_q     <= '0;
        dst_addr_q     <= '0;
        src_port_q     <= '0;
        dst_port_q     <= '0;
        flag_bits_q    <= '0;
      end else begin
        byte_count_q   <= byte_count_d;
        ether_kind_q   <= ether_kind_d;
        header_words_q <= header_words_d;
        proto_q        <= proto_d;
        src_addr_q     <= src_addr_d;
        dst_addr_q     <= dst_addr_d;
        src_port_q     <= src_port_d;
        dst_port_q     <= dst_port_d;
        flag_bits_q    <= flag_bits_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q   <= out_rec_d;
    out_user_q  <= out_user_d;
    skid_rec_q  <= skid_rec_d;
    skid_user_q <= skid_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_rec_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

// ===== hdl/l4hx_checker.sv =====
// Port-level checker for the header extractor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_l4_header_extractor_top_macros.svh"

module l4hx_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid_i,
  input wire logic                             m_axis_tready_i,
  input wire logic [l4hx_pkg::OUT_DATA_W-1:0]  m_axis_tdata_i,
  input wire logic                             m_axis_tuser_i
);

  l4hx_pkg::rec_t rec;
  assign rec = m_axis_tdata_i;

  // a stalled summary word holds
  `L4HX_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

  // a parsed frame is TCP or UDP
  `L4HX_ASSERT(a_valid_proto, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i |-> rec.proto_num == l4hx_pkg::PROTO_TCP || rec.proto_num == l4hx_pkg::PROTO_UDP)

  // ports and flags only on parsed frames
  `L4HX_ASSERT(a_invalid_zero, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tuser_i |-> rec.src_port == 16'h0000 && rec.dst_port == 16'h0000 && !rec.syn_flag && !rec.ack_flag && !rec.fin_flag)

  // UDP carries no TCP flags
  `L4HX_ASSERT(a_udp_noflags, clk_i, rst_ni, m_axis_tvalid_i && rec.proto_num == l4hx_pkg::PROTO_UDP |-> !rec.syn_flag && !rec.ack_flag && !rec.fin_flag)

  // an edge taken in reset leaves nothing offered at the next edge
  `L4HX_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_i)

endmodule

bind ipv4_l4_header_extractor_top l4hx_checker u_l4hx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
